// ===== rtl/core/lrss_pkg.sv =====
package lrss_pkg;

	localparam int HEIGHT_W = 11;
	localparam int ENERGY_W = 2 * HEIGHT_W;
	localparam int SUM_W    = ENERGY_W + 2;
	localparam int SLOT_W   = 5;
	localparam int LANES    = 3;

	typedef struct packed {
		logic                primary_present;
		logic [HEIGHT_W-1:0] primary_height;
		logic                secondary_present;
		logic [HEIGHT_W-1:0] secondary_height;
		logic                windsea_present;
		logic [HEIGHT_W-1:0] windsea_height;
	} item_t;

	typedef struct packed {
		logic              bulk_only;
		logic [SLOT_W-1:0] primary_slots;
		logic [SLOT_W-1:0] secondary_slots;
		logic [SLOT_W-1:0] windsea_slots;
		logic [SLOT_W-1:0] secondary_start;
		logic [SLOT_W-1:0] windsea_start;
	} result_t;

	typedef struct packed {
		logic [LANES-1:0] present;
		logic             sum_zero;
	} side_t;

endpackage

// ===== rtl/core/largest_remainder_slot_split_unit.sv =====
// Splits COMPONENTS slots among the present swell and wind sea partitions in proportion
// to squared height, largest remainder first, one slot minimum each. Fully pipelined: one
// transaction per cycle while result_ready is not held low. The restoring divider resolves
// one quotient bit per stage.
module largest_remainder_slot_split_unit #(
	parameter int COMPONENTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  lrss_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output lrss_pkg::result_t result
);

	localparam int QW  = $clog2(COMPONENTS + 1);
	localparam int DW  = lrss_pkg::SUM_W + QW;
	localparam int AW  = $clog2(COMPONENTS + 3);
	localparam int SLW = (AW > lrss_pkg::SLOT_W) ? AW : lrss_pkg::SLOT_W;
	localparam int Q1  = COMPONENTS;
	localparam int Q2  = COMPONENTS / 2;
	localparam int Q3  = COMPONENTS / 3;
	localparam int L   = lrss_pkg::LANES;

	function automatic logic [L-1:0][SLW-1:0] trim_one(input logic [L-1:0][SLW-1:0] s);
		logic [L-1:0][SLW-1:0] r;
		logic [1:0]            w;
		r = s;
		w = 2'd0;
		if (r[1] > r[w]) begin
			w = 2'd1;
		end
		if (r[2] > r[w]) begin
			w = 2'd2;
		end
		if (r[w] > SLW'(1)) begin
			r[w] = r[w] - SLW'(1);
		end
		return r;
	endfunction

	logic adv1, adv2, adv3, adv4, adv5;
	logic div_ready;

	// stage 1: energies
	logic                                     vld_s1;
	logic [L-1:0]                             pres_s1;
	logic [L-1:0][lrss_pkg::ENERGY_W-1:0]     e_s1;
	logic [L-1:0][lrss_pkg::HEIGHT_W-1:0]     hgt;

	// stage 2: sum and scaled numerators
	logic                                     vld_s2;
	logic [L-1:0][DW-1:0]                     num_s2;
	logic [lrss_pkg::SUM_W-1:0]               sum_s2;
	lrss_pkg::side_t                          side_s2;
	logic [L-1:0][lrss_pkg::ENERGY_W-1:0]     e_m;
	logic [L-1:0][DW-1:0]                     num_nx;
	logic [lrss_pkg::SUM_W-1:0]               sum_nx;

	// divider outputs
	logic                                     div_valid;
	logic [L-1:0][QW-1:0]                     div_q;
	logic [L-1:0][lrss_pkg::SUM_W-1:0]        div_rem;
	lrss_pkg::side_t                          div_side;

	// stage 3: floors and leftover
	logic                                     vld_s3;
	logic [L-1:0]                             pres_s3;
	logic [L-1:0][SLW-1:0]                    slots_s3;
	logic [SLW-1:0]                           excess_s3;
	logic [1:0]                               cnt;
	logic [SLW-1:0]                           qsz;
	logic [L-1:0][SLW-1:0]                    base;
	logic [L-1:0][lrss_pkg::SUM_W-1:0]        rr;
	logic [L-1:0][1:0]                        rank;
	logic [SLW-1:0]                           assigned;
	logic [SLW-1:0]                           left;
	logic [L-1:0][SLW-1:0]                    slots3_nx;

	// stage 4: first trim step
	logic                                     vld_s4;
	logic [L-1:0]                             pres_s4;
	logic [L-1:0][SLW-1:0]                    slots_s4;
	logic [SLW-1:0]                           excess_s4;

	// stage 5: second trim step and result
	logic                                     vld_s5;
	lrss_pkg::result_t                        result_s5;
	logic [L-1:0][SLW-1:0]                    sl5;
	logic [SLW:0]                             start2;
	lrss_pkg::result_t                        result_nx;

	assign adv5       = !vld_s5 || result_ready;
	assign adv4       = !vld_s4 || adv5;
	assign adv3       = !vld_s3 || adv4;
	assign adv2       = !vld_s2 || div_ready;
	assign adv1       = !vld_s1 || adv2;
	assign item_ready = adv1;

	assign result_valid = vld_s5;
	assign result       = result_s5;

	assign hgt[0] = item.primary_height;
	assign hgt[1] = item.secondary_height;
	assign hgt[2] = item.windsea_height;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (adv1) begin
				vld_s1 <= item_valid;
			end
			if (adv2) begin
				vld_s2 <= vld_s1;
			end
			if (adv3) begin
				vld_s3 <= div_valid;
			end
			if (adv4) begin
				vld_s4 <= vld_s3;
			end
			if (adv5) begin
				vld_s5 <= vld_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			pres_s1 <= {item.windsea_present, item.secondary_present, item.primary_present};
			for (int l = 0; l < L; l++) begin
				e_s1[l] <= lrss_pkg::ENERGY_W'(hgt[l]) * lrss_pkg::ENERGY_W'(hgt[l]);
			end
		end
	end

	always_comb begin
		for (int l = 0; l < L; l++) begin
			e_m[l]    = pres_s1[l] ? e_s1[l] : '0;
			num_nx[l] = DW'(COMPONENTS) * DW'(e_m[l]);
		end
		sum_nx = lrss_pkg::SUM_W'(e_m[0]) + lrss_pkg::SUM_W'(e_m[1])
			+ lrss_pkg::SUM_W'(e_m[2]);
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			num_s2           <= num_nx;
			sum_s2           <= sum_nx;
			side_s2.present  <= pres_s1;
			side_s2.sum_zero <= (sum_nx == '0);
		end
	end

	lrss_divider #(
		.COMPONENTS(COMPONENTS)
	) u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.in_ready  (div_ready),
		.in_num    (num_s2),
		.in_sum    (sum_s2),
		.in_side   (side_s2),
		.out_valid (div_valid),
		.out_ready (adv3),
		.out_q     (div_q),
		.out_rem   (div_rem),
		.out_side  (div_side)
	);

	always_comb begin
		cnt = 2'($countones(div_side.present));
		case (cnt)
			2'd1:    qsz = SLW'(Q1);
			2'd2:    qsz = SLW'(Q2);
			default: qsz = SLW'(Q3);
		endcase
		for (int l = 0; l < L; l++) begin
			if (div_side.sum_zero) begin
				base[l] = qsz;
				rr[l]   = '0;
			end else begin
				base[l] = SLW'(div_q[l]);
				rr[l]   = div_rem[l];
			end
			if (!div_side.present[l]) begin
				base[l] = '0;
			end else if (base[l] == '0) begin
				base[l] = SLW'(1);
			end
		end
		assigned = base[0] + base[1] + base[2];
		left     = (assigned < SLW'(COMPONENTS)) ? SLW'(COMPONENTS) - assigned : '0;
		for (int l = 0; l < L; l++) begin
			rank[l] = 2'd0;
			for (int j = 0; j < L; j++) begin
				if (div_side.present[j] && j != l
					&& (rr[j] > rr[l] || (rr[j] == rr[l] && j < l))) begin
					rank[l] = rank[l] + 2'd1;
				end
			end
			slots3_nx[l] = base[l];
			if (div_side.present[l] && SLW'(rank[l]) < left) begin
				slots3_nx[l] = base[l] + SLW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			pres_s3   <= div_side.present;
			slots_s3  <= slots3_nx;
			excess_s3 <= (assigned > SLW'(COMPONENTS)) ? assigned - SLW'(COMPONENTS) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			pres_s4 <= pres_s3;
			if (excess_s3 != '0) begin
				slots_s4  <= trim_one(slots_s3);
				excess_s4 <= excess_s3 - SLW'(1);
			end else begin
				slots_s4  <= slots_s3;
				excess_s4 <= excess_s3;
			end
		end
	end

	always_comb begin
		sl5    = (excess_s4 != '0) ? trim_one(slots_s4) : slots_s4;
		start2 = (SLW + 1)'(sl5[0]) + (SLW + 1)'(sl5[1]);
		result_nx.bulk_only       = (pres_s4 == '0);
		result_nx.primary_slots   = sl5[0][lrss_pkg::SLOT_W-1:0];
		result_nx.secondary_slots = sl5[1][lrss_pkg::SLOT_W-1:0];
		result_nx.windsea_slots   = sl5[2][lrss_pkg::SLOT_W-1:0];
		result_nx.secondary_start = sl5[0][lrss_pkg::SLOT_W-1:0];
		result_nx.windsea_start   = start2[lrss_pkg::SLOT_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			result_s5 <= result_nx;
		end
	end

	// leftover handout fills the budget exactly when no trim is pending
	a_budget_filled: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && excess_s3 == '0 && pres_s3 != '0
		|-> (SLW + 2)'(slots_s3[0]) + (SLW + 2)'(slots_s3[1]) + (SLW + 2)'(slots_s3[2])
			== (SLW + 2)'(COMPONENTS))
		else $error("slot total differs from budget");

	// floor of one slot for present partitions only
	a_floor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> ((slots_s3[0] == '0) == !pres_s3[0])
			&& ((slots_s3[1] == '0) == !pres_s3[1])
			&& ((slots_s3[2] == '0) == !pres_s3[2]))
		else $error("slot floor violated");

	// at most two floor bumps can overshoot the budget
	a_excess_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> excess_s3 <= SLW'(2))
		else $error("excess exceeds trim steps");

endmodule

// ===== rtl/core/lrss_divider.sv =====
module lrss_divider #(
	parameter int COMPONENTS = 16
) (
	input  logic                                                     clk,
	input  logic                                                     arst_n,
	input  logic                                                     in_valid,
	output logic                                                     in_ready,
	input  logic [lrss_pkg::LANES-1:0][lrss_pkg::SUM_W+$clog2(COMPONENTS+1)-1:0] in_num,
	input  logic [lrss_pkg::SUM_W-1:0]                               in_sum,
	input  lrss_pkg::side_t                                          in_side,
	output logic                                                     out_valid,
	input  logic                                                     out_ready,
	output logic [lrss_pkg::LANES-1:0][$clog2(COMPONENTS+1)-1:0]     out_q,
	output logic [lrss_pkg::LANES-1:0][lrss_pkg::SUM_W-1:0]          out_rem,
	output lrss_pkg::side_t                                          out_side
);

	localparam int QW = $clog2(COMPONENTS + 1);
	localparam int DW = lrss_pkg::SUM_W + QW;

	logic [QW-1:0] vld_s;
	logic [QW:0]   adv;

	logic [lrss_pkg::LANES-1:0][DW-1:0] rem_s [QW];
	logic [lrss_pkg::LANES-1:0][QW-1:0] q_s [QW];
	logic [lrss_pkg::SUM_W-1:0]         sum_s [QW];
	lrss_pkg::side_t                    side_s [QW];

	assign adv[QW]   = out_ready;
	assign in_ready  = adv[0];
	assign out_valid = vld_s[QW-1];
	assign out_side  = side_s[QW-1];

	always_comb begin
		for (int l = 0; l < lrss_pkg::LANES; l++) begin
			out_q[l]   = q_s[QW-1][l];
			out_rem[l] = rem_s[QW-1][l][lrss_pkg::SUM_W-1:0];
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_stage
		localparam int B = QW - 1 - j;

		logic                                vld_in;
		logic [lrss_pkg::LANES-1:0][DW-1:0] rem_in;
		logic [lrss_pkg::LANES-1:0][QW-1:0] q_in;
		logic [lrss_pkg::SUM_W-1:0]         sum_in;
		lrss_pkg::side_t                    side_in;
		logic [DW-1:0]                      dvs;
		logic [lrss_pkg::LANES-1:0][DW-1:0] rem_nx;
		logic [lrss_pkg::LANES-1:0][QW-1:0] q_nx;

		if (j == 0) begin : g_first
			assign vld_in  = in_valid;
			assign rem_in  = in_num;
			assign q_in    = '0;
			assign sum_in  = in_sum;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[j-1];
			assign rem_in  = rem_s[j-1];
			assign q_in    = q_s[j-1];
			assign sum_in  = sum_s[j-1];
			assign side_in = side_s[j-1];
		end

		assign adv[j] = !vld_s[j] || adv[j+1];
		assign dvs    = DW'(sum_in) << B;

		always_comb begin
			for (int l = 0; l < lrss_pkg::LANES; l++) begin
				if (rem_in[l] >= dvs) begin
					rem_nx[l] = rem_in[l] - dvs;
					q_nx[l]   = {q_in[l][QW-2:0], 1'b1};
				end else begin
					rem_nx[l] = rem_in[l];
					q_nx[l]   = {q_in[l][QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (adv[j]) begin
				vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[j]) begin
				rem_s[j]  <= rem_nx;
				q_s[j]    <= q_nx;
				sum_s[j]  <= sum_in;
				side_s[j] <= side_in;
			end
		end
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int COMPONENTS = 16;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              item_valid;
	logic              item_ready;
	lrss_pkg::item_t   item;
	logic              result_valid;
	logic              result_ready;
	lrss_pkg::result_t result;

	lrss_pkg::result_t pending_splits[$];
	int      mismatch_count = 0;
	int      tx_max = 15;
	int      rx_max = 15;
	int      rx_hold = 0;

	largest_remainder_slot_split_unit #(.COMPONENTS(COMPONENTS)) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #1 clk = ~clk;

	function automatic lrss_pkg::result_t slot_split(input lrss_pkg::item_t x);
		logic [2:0]        pres;
		longint unsigned   hgt[3];
		int                lane_of[3];
		longint unsigned   slots[3];
		longint signed     rem[3];
		longint unsigned   alloc[3];
		longint unsigned   sum;
		longint unsigned   assigned;
		longint unsigned   num;
		longint unsigned   q;
		longint unsigned   r;
		int                n;
		int                best;
		int                worst;
		lrss_pkg::result_t res;
		pres = {x.windsea_present, x.secondary_present, x.primary_present};
		hgt[0] = 64'(x.primary_height);
		hgt[1] = 64'(x.secondary_height);
		hgt[2] = 64'(x.windsea_height);
		n = 0;
		sum = 0;
		assigned = 0;
		res = '0;
		for (int k = 0; k < 3; k++) begin
			slots[k] = 0;
			rem[k] = 0;
			alloc[k] = 0;
			lane_of[k] = 0;
			if (pres[k]) begin
				lane_of[n] = k;
				n++;
			end
		end
		if (n == 0) begin
			res.bulk_only = 1'b1;
			return res;
		end
		for (int k = 0; k < n; k++)
			sum += hgt[lane_of[k]] * hgt[lane_of[k]];
		for (int k = 0; k < n; k++) begin
			if (sum > 0) begin
				num = 64'(COMPONENTS) * hgt[lane_of[k]] * hgt[lane_of[k]];
				q = num / sum;
				r = num % sum;
			end else begin
				q = 64'(COMPONENTS / n);
				r = 64'(COMPONENTS % n);
			end
			slots[k] = (q < 1) ? 1 : q;
			rem[k] = longint'(r);
			assigned += slots[k];
		end
		// leftovers by largest remainder, each partition once
		while (assigned < COMPONENTS) begin
			best = 0;
			for (int k = 1; k < n; k++)
				if (rem[k] > rem[best])
					best = k;
			slots[best] += 1;
			rem[best] = -1;
			assigned += 1;
		end
		// claw back from the fullest, keeping one slot each
		while (assigned > COMPONENTS) begin
			worst = 0;
			for (int k = 1; k < n; k++)
				if (slots[k] > slots[worst])
					worst = k;
			if (slots[worst] <= 1)
				break;
			slots[worst] -= 1;
			assigned -= 1;
		end
		for (int k = 0; k < n; k++)
			alloc[lane_of[k]] = slots[k];
		res.primary_slots   = lrss_pkg::SLOT_W'(alloc[0]);
		res.secondary_slots = lrss_pkg::SLOT_W'(alloc[1]);
		res.windsea_slots   = lrss_pkg::SLOT_W'(alloc[2]);
		res.secondary_start = lrss_pkg::SLOT_W'(alloc[0]);
		res.windsea_start   = lrss_pkg::SLOT_W'(alloc[0] + alloc[1]);
		return res;
	endfunction

	function automatic lrss_pkg::item_t make_item(input int pp, input int ph, input int sp,
			input int sh, input int wp, input int wh);
		lrss_pkg::item_t x;
		x.primary_present   = 1'(pp);
		x.primary_height    = lrss_pkg::HEIGHT_W'(ph);
		x.secondary_present = 1'(sp);
		x.secondary_height  = lrss_pkg::HEIGHT_W'(sh);
		x.windsea_present   = 1'(wp);
		x.windsea_height    = lrss_pkg::HEIGHT_W'(wh);
		return x;
	endfunction

	function automatic logic [lrss_pkg::HEIGHT_W-1:0] rand_height(
			input logic [lrss_pkg::HEIGHT_W-1:0] base);
		case ($urandom_range(7, 0))
			0: return '0;
			1: return '1;
			2: return lrss_pkg::HEIGHT_W'($urandom_range(15, 0));
			3: return base;
			4: return lrss_pkg::HEIGHT_W'(base + $urandom_range(3, 0));
			default: return lrss_pkg::HEIGHT_W'($urandom);
		endcase
	endfunction

	function automatic lrss_pkg::item_t rand_item();
		logic [lrss_pkg::HEIGHT_W-1:0] base;
		base = lrss_pkg::HEIGHT_W'($urandom);
		return make_item(int'($urandom_range(1, 0)), int'(rand_height(base)),
			int'($urandom_range(1, 0)), int'(rand_height(base)),
			int'($urandom_range(1, 0)), int'(rand_height(base)));
	endfunction

	task automatic send_item(input lrss_pkg::item_t x);
		int gap;
		gap = (tx_max == 0) ? 0 : $urandom_range(tx_max, 0);
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item <= x;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		pending_splits.push_back(slot_split(x));
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_splits.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(input string name, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			if (mismatch_count < 10)
				$display("mismatch %s: expected %0d, got %0d", name, exp_v, got_v);
			mismatch_count++;
		end
	endtask

	// receiver
	initial begin
		int stall;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				stall = rx_hold;
				rx_hold = 0;
			end else begin
				stall = (rx_max == 0) ? 0 : $urandom_range(rx_max, 0);
			end
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!(result_valid && result_ready)) @(posedge clk);
		end
	end

	// result checker
	always @(posedge clk) begin
		lrss_pkg::result_t exp_r;
		if (arst_n && result_valid && result_ready) begin
			if (pending_splits.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected transaction: %p", result);
				mismatch_count++;
			end else begin
				exp_r = pending_splits.pop_front();
				check_field("bulk_only", int'(exp_r.bulk_only), int'(result.bulk_only));
				check_field("primary_slots", int'(exp_r.primary_slots),
					int'(result.primary_slots));
				check_field("secondary_slots", int'(exp_r.secondary_slots),
					int'(result.secondary_slots));
				check_field("windsea_slots", int'(exp_r.windsea_slots),
					int'(result.windsea_slots));
				check_field("secondary_start", int'(exp_r.secondary_start),
					int'(result.secondary_start));
				check_field("windsea_start", int'(exp_r.windsea_start),
					int'(result.windsea_start));
			end
		end
	end

	task automatic test_directed();
		tx_max = 3;
		rx_max = 3;
		send_item(make_item(0, 2047, 0, 2047, 0, 2047));
		send_item(make_item(0, 0, 0, 0, 0, 0));
		send_item(make_item(1, 0, 1, 0, 1, 0));
		send_item(make_item(1, 0, 0, 2047, 0, 2047));
		send_item(make_item(0, 0, 1, 2047, 0, 0));
		send_item(make_item(0, 2047, 0, 2047, 1, 1));
		send_item(make_item(1, 0, 1, 0, 0, 2047));
		send_item(make_item(0, 2047, 1, 0, 1, 0));
		send_item(make_item(1, 2047, 0, 0, 1, 2047));
		send_item(make_item(1, 2047, 1, 2047, 1, 2047));
		send_item(make_item(1, 100, 1, 100, 1, 100));
		send_item(make_item(1, 1, 1, 2047, 1, 2047));
		send_item(make_item(1, 2047, 1, 1, 1, 1));
		send_item(make_item(1, 0, 1, 0, 1, 2047));
		send_item(make_item(1, 3, 1, 4, 1, 5));
		send_item(make_item(1, 1365, 1, 682, 1, 1024));
		send_item(make_item(1, 682, 1, 1365, 0, 1365));
		send_item(make_item(1, 1, 0, 2047, 0, 2047));
		send_item(make_item(0, 0, 1, 2047, 1, 1));
		send_item(make_item(1, 2, 0, 0, 1, 1));
		send_item(make_item(1, 1, 1, 1, 1, 1));
		send_item(make_item(1, 2047, 1, 0, 1, 0));
	endtask

	task automatic test_random();
		int tx_pick[6] = '{15, 0, 15, 0, 3, 15};
		int rx_pick[6] = '{15, 0, 0, 15, 3, 15};
		for (int p = 0; p < 6; p++) begin
			tx_max = tx_pick[p];
			rx_max = rx_pick[p];
			repeat (200) send_item(rand_item());
		end
	endtask

	task automatic test_backpressure();
		tx_max = 0;
		rx_max = 0;
		rx_hold = 400;
		repeat (60) send_item(rand_item());
	endtask

	task automatic test_drain_pause();
		tx_max = 7;
		rx_max = 7;
		repeat (20) send_item(rand_item());
		wait_for_results();
		repeat (20) send_item(rand_item());
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random();
		test_backpressure();
		test_drain_pause();
		wait_for_results();
		repeat (30) @(posedge clk);
		if (mismatch_count == 0 && pending_splits.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#1000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
